FILE: sv/tle_pkg.sv
// ----------------------------------------------------------------------------
// tle_pkg
// Shared widths, limits and the result type of the tour length evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package tle_pkg;

  localparam int TOTAL_W = 27;
  localparam int COUNT_W = 16;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef struct packed {
    logic [TOTAL_W-1:0] tour_length;
    logic [COUNT_W-1:0] city_count;
    logic               overflowed;
  } result_t;

endpackage

`default_nettype wire

FILE: sv/tle_city_if.sv
// ----------------------------------------------------------------------------
// tle_city_if
// Request channel that carries one city of a tour per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface tle_city_if #(
  parameter int COORD_BITS = 16
) ();

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] x_coord;
  logic signed [COORD_BITS-1:0] y_coord;
  logic                         last_city;

  modport source (output valid, x_coord, y_coord, last_city, input ready);
  modport sink   (input valid, x_coord, y_coord, last_city, output ready);

endinterface

`default_nettype wire

FILE: sv/tle_tour_if.sv
// ----------------------------------------------------------------------------
// tle_tour_if
// Result channel that carries one finished tour per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface tle_tour_if import tle_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] tour_length;
  logic [COUNT_W-1:0] city_count;
  logic               overflowed;

  modport source (output valid, tour_length, city_count, overflowed, input ready);
  modport sink   (input valid, tour_length, city_count, overflowed, output ready);

endinterface

`default_nettype wire

FILE: sv/tle_front.sv
// ----------------------------------------------------------------------------
// tle_front
// Takes cities, tracks the first and previous city and the city count, and
// turns each city into zero, one or two leg jobs of absolute deltas.
// ----------------------------------------------------------------------------
`default_nettype none

module tle_front import tle_pkg::*; #(
  parameter  int COORD_BITS = 16,
  localparam int AbsW       = COORD_BITS + 1,
  localparam int JobW       = 2 * AbsW + 1 + COUNT_W
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  tle_city_if.sink             city_i,
  output      logic            push_valid_o,
  input  wire logic            push_ready_i,
  output      logic [JobW-1:0] push_data_o
);

  typedef struct packed {
    logic [AbsW-1:0]    abs_x;
    logic [AbsW-1:0]    abs_y;
    logic               emit;
    logic [COUNT_W-1:0] count;
  } job_t;

  function automatic logic [AbsW-1:0] abs_diff(input logic signed [COORD_BITS-1:0] a,
                                               input logic signed [COORD_BITS-1:0] b);
    logic signed [AbsW-1:0] d;
    d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    return d[AbsW-1] ? AbsW'(-d) : AbsW'(d);
  endfunction

  logic signed [COORD_BITS-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic signed [COORD_BITS-1:0] leg_ax, leg_ay, leg_bx, leg_by;
  logic [COUNT_W-1:0]           count_q, count_inc;
  logic                         pend_q;
  logic                         is_first;
  logic                         accept;
  job_t                         job;

  assign is_first  = (count_q == '0);
  assign count_inc = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;
  assign city_i.ready = !pend_q && push_ready_i;
  assign accept    = city_i.valid && city_i.ready;

  always_comb begin
    if (pend_q) begin
      leg_ax = prev_x_q;
      leg_ay = prev_y_q;
      leg_bx = first_x_q;
      leg_by = first_y_q;
    end else if (is_first) begin
      leg_ax = city_i.x_coord;
      leg_ay = city_i.y_coord;
      leg_bx = city_i.x_coord;
      leg_by = city_i.y_coord;
    end else begin
      leg_ax = prev_x_q;
      leg_ay = prev_y_q;
      leg_bx = city_i.x_coord;
      leg_by = city_i.y_coord;
    end
  end

  always_comb begin
    job.abs_x = abs_diff(leg_ax, leg_bx);
    job.abs_y = abs_diff(leg_ay, leg_by);
    job.emit  = pend_q || is_first;
    job.count = pend_q ? count_q : count_inc;
  end

  assign push_valid_o = pend_q || (city_i.valid && (!is_first || city_i.last_city));
  assign push_data_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pend_q  <= 1'b0;
    end else if (pend_q) begin
      if (push_ready_i) begin
        count_q <= '0;
        pend_q  <= 1'b0;
      end
    end else if (accept) begin
      if (city_i.last_city && is_first) begin
        count_q <= '0;
      end else begin
        count_q <= count_inc;
        pend_q  <= city_i.last_city;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prev_x_q <= city_i.x_coord;
      prev_y_q <= city_i.y_coord;
      if (is_first) begin
        first_x_q <= city_i.x_coord;
        first_y_q <= city_i.y_coord;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/tle_job_fifo.sv
// ----------------------------------------------------------------------------
// tle_job_fifo
// Short register queue of leg jobs between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module tle_job_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output      logic             push_ready_o,
  input  wire logic [WIDTH-1:0] push_data_i,
  output      logic             pop_valid_o,
  input  wire logic             pop_ready_i,
  output      logic [WIDTH-1:0] pop_data_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             push, pop;

  assign push_ready_o = (count_q != CntFull);
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("Job queue count exceeds its depth.");

  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == CntFull && !pop_ready_i) |=> (count_q == CntFull))
    else $error("Job queue lost an entry while full and stalled.");

endmodule

`default_nettype wire

FILE: sv/tle_back.sv
// ----------------------------------------------------------------------------
// tle_back
// Squares the leg deltas, takes the floor square root one result bit per
// cycle, accumulates the saturating total and presents finished tours.
// ----------------------------------------------------------------------------
`default_nettype none

module tle_back import tle_pkg::*; #(
  parameter  int COORD_BITS = 16,
  localparam int AbsW       = COORD_BITS + 1,
  localparam int JobW       = 2 * AbsW + 1 + COUNT_W
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            pop_valid_i,
  output      logic            pop_ready_o,
  input  wire logic [JobW-1:0] pop_data_i,
  tle_tour_if.source           tour_o
);

  localparam int SqW   = 2 * AbsW;
  localparam int SumW  = SqW + 1;
  localparam int RootW = AbsW + 1;
  localparam int RadW  = 2 * RootW;
  localparam int RemW  = RootW + 2;
  localparam int ItW   = $clog2(RootW + 1);
  localparam logic [ItW-1:0] IterLast = ItW'(RootW - 1);

  typedef struct packed {
    logic [AbsW-1:0]    abs_x;
    logic [AbsW-1:0]    abs_y;
    logic               emit;
    logic [COUNT_W-1:0] count;
  } job_t;

  typedef enum logic [4:0] {
    BK_IDLE = 5'b00001,
    BK_MUL  = 5'b00010,
    BK_SUM  = 5'b00100,
    BK_ROOT = 5'b01000,
    BK_ACC  = 5'b10000
  } back_state_e;

  back_state_e        state_q, state_d;
  job_t               job_q;
  logic [SqW-1:0]     sq_x_q, sq_y_q;
  logic [SumW-1:0]    sum;
  logic [RadW-1:0]    rad_q;
  logic [RemW-1:0]    rem_q;
  logic [RootW-1:0]   root_q;
  logic [ItW-1:0]     iter_q;
  logic [RemW+1:0]    rem_shift, trial;
  logic               fits;
  logic [TOTAL_W-1:0] total_q, total_new;
  logic [TOTAL_W:0]   acc_sum;
  logic               sat_q, ovf;
  logic               acc_done;
  logic               out_valid_q;
  result_t            out_q;

  assign pop_ready_o = (state_q == BK_IDLE);

  assign sum       = {1'b0, sq_x_q} + {1'b0, sq_y_q};
  assign rem_shift = {rem_q, rad_q[RadW-1 -: 2]};
  assign trial     = {2'b00, root_q, 2'b01};
  assign fits      = (rem_shift >= trial);

  assign acc_sum   = {1'b0, total_q} + (TOTAL_W + 1)'(root_q);
  assign ovf       = acc_sum[TOTAL_W];
  assign total_new = ovf ? TOTAL_MAX : acc_sum[TOTAL_W-1:0];
  assign acc_done  = (state_q == BK_ACC) && (!job_q.emit || !out_valid_q || tour_o.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (pop_valid_i) state_d = BK_MUL;
      end
      BK_MUL:  state_d = BK_SUM;
      BK_SUM:  state_d = BK_ROOT;
      BK_ROOT: begin
        if (iter_q == IterLast) state_d = BK_ACC;
      end
      BK_ACC: begin
        if (acc_done) state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      total_q     <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (acc_done) begin
        if (job_q.emit) begin
          total_q <= '0;
          sat_q   <= 1'b0;
        end else begin
          total_q <= total_new;
          sat_q   <= sat_q || ovf;
        end
      end
      if (acc_done && job_q.emit) begin
        out_valid_q <= 1'b1;
      end else if (tour_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BK_IDLE: begin
        if (pop_valid_i) job_q <= job_t'(pop_data_i);
      end
      BK_MUL: begin
        sq_x_q <= job_q.abs_x * job_q.abs_x;
        sq_y_q <= job_q.abs_y * job_q.abs_y;
      end
      BK_SUM: begin
        rad_q  <= {1'b0, sum};
        rem_q  <= '0;
        root_q <= '0;
        iter_q <= '0;
      end
      BK_ROOT: begin
        rad_q  <= {rad_q[RadW-3:0], 2'b00};
        iter_q <= iter_q + 1'b1;
        if (fits) begin
          rem_q  <= RemW'(rem_shift - trial);
          root_q <= {root_q[RootW-2:0], 1'b1};
        end else begin
          rem_q  <= RemW'(rem_shift);
          root_q <= {root_q[RootW-2:0], 1'b0};
        end
      end
      BK_ACC: begin
        if (acc_done && job_q.emit) begin
          out_q.tour_length <= total_new;
          out_q.city_count  <= job_q.count;
          out_q.overflowed  <= sat_q || ovf;
        end
      end
      default: begin
      end
    endcase
  end

  assign tour_o.valid       = out_valid_q;
  assign tour_o.tour_length = out_q.tour_length;
  assign tour_o.city_count  = out_q.city_count;
  assign tour_o.overflowed  = out_q.overflowed;

  a_root_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_ROOT && iter_q == IterLast) |=> (state_q == BK_ACC))
    else $error("Square root did not finish after its last iteration.");

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_done && job_q.emit) |=> (out_valid_q && total_q == '0 && !sat_q))
    else $error("Finished tour was not presented or the total was not cleared.");

endmodule

`default_nettype wire

FILE: sv/tour_length_evaluator.sv
// ----------------------------------------------------------------------------
// tour_length_evaluator
// Closed Euclidean tour length over cities given in visiting order.
// ----------------------------------------------------------------------------
// Each leg holds the back end through pop, square, sum, one root bit per cycle
// over COORD_BITS + 2 bits and accumulate, and no new leg is popped meanwhile.
// A city costs one leg, the first city of a tour none and the last city two; a
// lone city costs one zero-length leg. The serial root sets the throughput.
// A tour's result is registered when the back end accumulates the leg that closes it.
// Reset is asynchronous and active low; it empties the queue and clears the tour.
// ----------------------------------------------------------------------------
`default_nettype none

module tour_length_evaluator import tle_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int JOB_DEPTH  = 4
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tle_city_if.sink   city_i,
  tle_tour_if.source tour_o
);

  localparam int JobW = 2 * (COORD_BITS + 1) + 1 + COUNT_W;

  logic            push_valid, push_ready;
  logic [JobW-1:0] push_data;
  logic            pop_valid, pop_ready;
  logic [JobW-1:0] pop_data;

  tle_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .city_i       (city_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  tle_job_fifo #(
    .WIDTH (JobW),
    .DEPTH (JOB_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  tle_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .tour_o      (tour_o)
  );

endmodule

`default_nettype wire
